// ===== hw/rtl/trot_gait_foot_trajectory_unit_macros.svh =====
// assertion macros for the trot gait foot trajectory unit
`ifndef TROT_GAIT_FOOT_TRAJECTORY_UNIT_MACROS_SVH
`define TROT_GAIT_FOOT_TRAJECTORY_UNIT_MACROS_SVH

// consequent checked in the same cycle
`define TGFT_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the following cycle
`define TGFT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tgft_pkg.sv =====
package tgft_pkg;

  localparam int NUM_LEGS   = 4;
  localparam int LEG_W      = 2;
  localparam int ELAPSED_W  = 16;
  localparam int POS_W      = 17;
  localparam int MODE_W     = 3;
  localparam int LEN_W      = 12;
  localparam int RATE_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int TRIG_W     = 17;

  localparam logic [LEG_W-1:0] LAST_LEG = LEG_W'(NUM_LEGS - 1);

  localparam logic [MODE_W-1:0] MODE_STOP         = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FORWARD      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BACKWARD     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STRAFE_LEFT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_STRAFE_RIGHT = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ROTATE_LEFT  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_ROTATE_RIGHT = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED       = 3'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIT_MODE     = 3'd0,
    CFG_BASE_X        = 3'd1,
    CFG_BASE_Y        = 3'd2,
    CFG_BASE_Z        = 3'd3,
    CFG_STRIDE_LENGTH = 3'd4,
    CFG_LIFT_HEIGHT   = 3'd5,
    CFG_PHASE_RATE    = 3'd6
  } cfg_idx_t;

  // sine magnitude, cosine magnitude and cosine sign, q16
  typedef struct packed {
    logic [TRIG_W-1:0] sn;
    logic [TRIG_W-1:0] cs_mag;
    logic              cs_neg;
  } trig_t;

endpackage

// ===== hw/rtl/tgft_ifs.sv =====
interface tgft_tick_if;
  logic                           valid;
  logic                           ready;
  logic [tgft_pkg::ELAPSED_W-1:0] elapsed_ms;

  modport source (output valid, output elapsed_ms, input ready);
  modport sink   (input valid, input elapsed_ms, output ready);
endinterface

interface tgft_foot_if;
  logic                              valid;
  logic                              ready;
  logic [tgft_pkg::LEG_W-1:0]        leg;
  logic signed [tgft_pkg::POS_W-1:0] foot_x;
  logic signed [tgft_pkg::POS_W-1:0] foot_y;
  logic signed [tgft_pkg::POS_W-1:0] foot_z;
  logic                              last_leg;

  modport source (output valid, output leg, output foot_x, output foot_y, output foot_z,
                  output last_leg, input ready);
  modport sink   (input valid, input leg, input foot_x, input foot_y, input foot_z,
                  input last_leg, output ready);
endinterface

// ===== hw/rtl/tgft_trig_lut.sv =====
module tgft_trig_lut #(
  parameter int DEPTH = 256
) (
  input  logic [$clog2(2*DEPTH)-1:0] angle,
  output tgft_pkg::trig_t            trig
);

  localparam int AW = $clog2(2*DEPTH);
  localparam int IW = $clog2(DEPTH+1);
  localparam logic [AW:0] D_C   = (AW+1)'(DEPTH);
  localparam logic [AW:0] TWO_D = (AW+1)'(2*DEPTH);

  typedef logic [tgft_pkg::TRIG_W-1:0] qs_tab_t [0:DEPTH];

  function automatic longint hstep(longint c, longint r, longint s);
    longint rr;
    rr = (r < 0) ? 64'sd0 : r;
    return c - ((rr * s) >>> 30);
  endfunction

  // quarter-wave sine, q16, cosine series evaluated in q30
  function automatic qs_tab_t build_qs();
    qs_tab_t tab;
    longint  t;
    longint  s;
    longint  r;
    for (int k = 0; k <= DEPTH; k++) begin
      t = (longint'(DEPTH - k) <<< 30) / DEPTH;
      s = (t * t) >>> 30;
      r = 64'sd27060;
      r = hstep(64'sd987048, r, s);
      r = hstep(64'sd22401992, r, s);
      r = hstep(64'sd272375560, r, s);
      r = hstep(64'sd1324675879, r, s);
      r = hstep(64'sd1073741824, r, s);
      if (r < 0) begin
        r = 64'sd0;
      end
      r = (r + 64'sd8192) >>> 14;
      if (r > 64'sd65536) begin
        r = 64'sd65536;
      end
      tab[k] = tgft_pkg::TRIG_W'(r);
    end
    return tab;
  endfunction

  localparam qs_tab_t QS = build_qs();

  logic [AW:0] a_ext;
  logic [AW:0] idx_s;
  logic [AW:0] idx_c;
  logic        neg;

  always_comb begin
    a_ext = {1'b0, angle};
    if (a_ext <= D_C) begin
      idx_s = a_ext;
      idx_c = D_C - a_ext;
      neg   = 1'b0;
    end else begin
      idx_s = TWO_D - a_ext;
      idx_c = a_ext - D_C;
      neg   = 1'b1;
    end
  end

  assign trig.sn     = QS[idx_s[IW-1:0]];
  assign trig.cs_mag = QS[idx_c[IW-1:0]];
  assign trig.cs_neg = neg;

endmodule

// ===== hw/rtl/trot_gait_foot_trajectory_unit.sv =====
// Trot gait foot trajectory unit. Each accepted tick word carries the milliseconds
// since the previous tick; in a walking mode the gait phase advances by
// elapsed_ms * phase_rate (modulo one gait period) and four foot-target words follow,
// legs 0 to 3 in order, the last one flagged by last_leg. Legs 1 and 2 run half a
// gait period behind legs 0 and 3. In stop mode (and the unused mode code) a tick is
// taken and gives no words. A walking tick occupies the leg sequencer until
// its four leg words have issued, one leg word per cycle while the output is
// not stalled; each word passes the angle, sine/cosine table, multiply, and
// round and saturate stages in that order before it appears. The
// next tick is taken in the cycle the last leg of the current one issues, and
// the whole pipe holds while the output word is not taken. Configuration words
// must be written only while the unit is idle. No clearing pass after reset.
`include "trot_gait_foot_trajectory_unit_macros.svh"

module trot_gait_foot_trajectory_unit #(
  parameter int PHASE_BITS       = 16,
  parameter int TRIG_TABLE_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  tgft_tick_if.sink                         in_tick,
  tgft_foot_if.source                       out_foot,
  input  logic                              cfg_we,
  input  logic [tgft_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [tgft_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int AW   = $clog2(2*TRIG_TABLE_DEPTH);
  localparam int PW   = PHASE_BITS - 1 + AW;
  localparam int PRDW = 29;

  typedef enum logic [1:0] {
    DIR_ZERO = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } dir_t;

  typedef struct packed {
    dir_t x;
    dir_t z;
  } dir_pair_t;

  typedef struct packed {
    logic [tgft_pkg::LEG_W-1:0] leg;
    logic                       last;
    logic                       swing;
    dir_pair_t                  dir;
  } tag_t;

  function automatic dir_pair_t dir_lookup(logic [tgft_pkg::MODE_W-1:0] mode,
                                           logic [tgft_pkg::LEG_W-1:0] leg);
    dir_pair_t d;
    d.x = DIR_ZERO;
    d.z = DIR_ZERO;
    unique case (mode)
      tgft_pkg::MODE_FORWARD:      d.x = DIR_NEG;
      tgft_pkg::MODE_BACKWARD:     d.x = DIR_POS;
      tgft_pkg::MODE_STRAFE_LEFT:  d.z = DIR_NEG;
      tgft_pkg::MODE_STRAFE_RIGHT: d.z = DIR_POS;
      tgft_pkg::MODE_ROTATE_LEFT: begin
        d.x = leg[0] ? DIR_NEG : DIR_POS;
        d.z = leg[1] ? DIR_POS : DIR_NEG;
      end
      tgft_pkg::MODE_ROTATE_RIGHT: begin
        d.x = leg[0] ? DIR_POS : DIR_NEG;
        d.z = leg[1] ? DIR_NEG : DIR_POS;
      end
      default: begin
        d.x = DIR_ZERO;
        d.z = DIR_ZERO;
      end
    endcase
    return d;
  endfunction

  function automatic logic [tgft_pkg::POS_W-1:0] sat_pos(logic [tgft_pkg::POS_W:0] v);
    logic [tgft_pkg::POS_W-1:0] r;
    if (v[tgft_pkg::POS_W] != v[tgft_pkg::POS_W-1]) begin
      r = v[tgft_pkg::POS_W] ? 17'h10000 : 17'h0FFFF;
    end else begin
      r = v[tgft_pkg::POS_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [tgft_pkg::POS_W-1:0] move_pos(logic [tgft_pkg::POS_W-1:0] base,
                                                          dir_t dir, logic mv_neg,
                                                          logic [tgft_pkg::LEN_W-1:0] mag);
    logic [tgft_pkg::POS_W:0] b;
    logic [tgft_pkg::POS_W:0] m;
    logic                     neg;
    logic [tgft_pkg::POS_W-1:0] r;
    b   = {base[tgft_pkg::POS_W-1], base};
    m   = {{(tgft_pkg::POS_W + 1 - tgft_pkg::LEN_W){1'b0}}, mag};
    neg = mv_neg ^ (dir == DIR_NEG);
    if (dir == DIR_ZERO) begin
      r = base;
    end else begin
      r = sat_pos(neg ? (b - m) : (b + m));
    end
    return r;
  endfunction

  // configuration
  logic [tgft_pkg::MODE_W-1:0] gait_mode_r;
  logic [tgft_pkg::POS_W-1:0]  base_x_r;
  logic [tgft_pkg::POS_W-1:0]  base_y_r;
  logic [tgft_pkg::POS_W-1:0]  base_z_r;
  logic [tgft_pkg::LEN_W-1:0]  stride_length_r;
  logic [tgft_pkg::LEN_W-1:0]  lift_height_r;
  logic [tgft_pkg::RATE_W-1:0] phase_rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gait_mode_r     <= tgft_pkg::MODE_STOP;
      base_x_r        <= 17'd0;
      base_y_r        <= 17'h1FB00;
      base_z_r        <= 17'd448;
      stride_length_r <= 12'd1280;
      lift_height_r   <= 12'd240;
      phase_rate_r    <= 16'd98;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tgft_pkg::CFG_GAIT_MODE:     gait_mode_r     <= cfg_wdata[tgft_pkg::MODE_W-1:0];
        tgft_pkg::CFG_BASE_X:        base_x_r        <= cfg_wdata;
        tgft_pkg::CFG_BASE_Y:        base_y_r        <= cfg_wdata;
        tgft_pkg::CFG_BASE_Z:        base_z_r        <= cfg_wdata;
        tgft_pkg::CFG_STRIDE_LENGTH: stride_length_r <= cfg_wdata[tgft_pkg::LEN_W-1:0];
        tgft_pkg::CFG_LIFT_HEIGHT:   lift_height_r   <= cfg_wdata[tgft_pkg::LEN_W-1:0];
        tgft_pkg::CFG_PHASE_RATE:    phase_rate_r    <= cfg_wdata[tgft_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // tick intake and leg sequencer
  logic                        walking;
  logic                        advance;
  logic                        in_fire;
  logic                        issue;
  logic                        issue_last;
  logic [31:0]                 step_prod;
  logic [PHASE_BITS-1:0]       phase_r;
  logic [PHASE_BITS-1:0]       phase_nxt;
  logic                        hold_valid_r;
  logic                        hold_valid_nxt;
  logic [tgft_pkg::LEG_W-1:0]  leg_cnt_r;
  logic [tgft_pkg::LEG_W-1:0]  leg_cnt_nxt;
  logic                        out_valid_r;

  assign walking    = (gait_mode_r >= tgft_pkg::MODE_FORWARD) &&
                      (gait_mode_r <= tgft_pkg::MODE_ROTATE_RIGHT);
  assign advance    = !out_valid_r || out_foot.ready;
  assign issue      = hold_valid_r && advance;
  assign issue_last = issue && (leg_cnt_r == tgft_pkg::LAST_LEG);
  assign in_tick.ready = !hold_valid_r || issue_last;
  assign in_fire    = in_tick.valid && in_tick.ready;
  assign step_prod  = 32'(in_tick.elapsed_ms) * 32'(phase_rate_r);

  always_comb begin
    phase_nxt      = phase_r;
    hold_valid_nxt = hold_valid_r;
    leg_cnt_nxt    = leg_cnt_r;
    if (issue) begin
      leg_cnt_nxt = leg_cnt_r + 1'b1;
    end
    if (issue_last) begin
      hold_valid_nxt = 1'b0;
    end
    if (in_fire && walking) begin
      phase_nxt      = phase_r + step_prod[PHASE_BITS-1:0];
      hold_valid_nxt = 1'b1;
    end
  end

  // pipe valid bits
  logic s1_valid_r;
  logic s2_valid_r;
  logic s3_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= '0;
      hold_valid_r <= 1'b0;
      leg_cnt_r    <= '0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      s3_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      hold_valid_r <= hold_valid_nxt;
      leg_cnt_r    <= leg_cnt_nxt;
      if (advance) begin
        s1_valid_r  <= hold_valid_r;
        s2_valid_r  <= s1_valid_r;
        s3_valid_r  <= s2_valid_r;
        out_valid_r <= s3_valid_r;
      end
    end
  end

  // stage 1: leg phase and table angle
  logic [PHASE_BITS-1:0] leg_phase;
  logic [PW-1:0]         angle_prod;
  tag_t                  s1_tag;
  tag_t                  s1_tag_r;
  logic [AW-1:0]         s1_angle_r;

  always_comb begin
    leg_phase        = phase_r;
    leg_phase[PHASE_BITS-1] = phase_r[PHASE_BITS-1] ^ (leg_cnt_r[0] ^ leg_cnt_r[1]);
    angle_prod       = PW'(leg_phase[PHASE_BITS-2:0]) * PW'(2*TRIG_TABLE_DEPTH);
    s1_tag.leg       = leg_cnt_r;
    s1_tag.last      = (leg_cnt_r == tgft_pkg::LAST_LEG);
    s1_tag.swing     = !leg_phase[PHASE_BITS-1];
    s1_tag.dir       = dir_lookup(gait_mode_r, leg_cnt_r);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_tag_r   <= s1_tag;
      s1_angle_r <= angle_prod[PW-1 -: AW];
    end
  end

  // stage 2: sine and cosine
  tgft_pkg::trig_t trig;

  tgft_trig_lut #(
    .DEPTH (TRIG_TABLE_DEPTH)
  ) u_trig (
    .angle (s1_angle_r),
    .trig  (trig)
  );

  tag_t                        s2_tag_r;
  logic [tgft_pkg::TRIG_W-1:0] s2_sn_r;
  logic [tgft_pkg::TRIG_W-1:0] s2_mv_mag_r;
  logic                        s2_mv_neg_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_tag_r    <= s1_tag_r;
      s2_sn_r     <= trig.sn;
      s2_mv_mag_r <= trig.cs_mag;
      s2_mv_neg_r <= s1_tag_r.swing ^ trig.cs_neg;
    end
  end

  // stage 3: lift and stride products
  tag_t            s3_tag_r;
  logic            s3_mv_neg_r;
  logic [PRDW-1:0] s3_lift_prod_r;
  logic [PRDW-1:0] s3_move_prod_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_tag_r       <= s2_tag_r;
      s3_mv_neg_r    <= s2_mv_neg_r;
      s3_lift_prod_r <= PRDW'(lift_height_r) * PRDW'(s2_sn_r);
      s3_move_prod_r <= PRDW'(stride_length_r) * PRDW'(s2_mv_mag_r);
    end
  end

  // stage 4: round, offset and saturate into the output register
  logic [PRDW-1:0]             lift_rnd;
  logic [PRDW-1:0]             move_rnd;
  logic [tgft_pkg::POS_W:0]    y_sum;
  logic [tgft_pkg::POS_W-1:0]  fx;
  logic [tgft_pkg::POS_W-1:0]  fy;
  logic [tgft_pkg::POS_W-1:0]  fz;

  always_comb begin
    lift_rnd = (s3_lift_prod_r + PRDW'(32768)) >> 16;
    move_rnd = (s3_move_prod_r + PRDW'(65536)) >> 17;
    y_sum    = {base_y_r[tgft_pkg::POS_W-1], base_y_r} + {6'b0, lift_rnd[11:0]};
    fy       = s3_tag_r.swing ? sat_pos(y_sum) : base_y_r;
    fx       = move_pos(base_x_r, s3_tag_r.dir.x, s3_mv_neg_r, move_rnd[tgft_pkg::LEN_W-1:0]);
    fz       = move_pos(base_z_r, s3_tag_r.dir.z, s3_mv_neg_r, move_rnd[tgft_pkg::LEN_W-1:0]);
  end

  logic [tgft_pkg::LEG_W-1:0] out_leg_r;
  logic                       out_last_r;
  logic [tgft_pkg::POS_W-1:0] out_x_r;
  logic [tgft_pkg::POS_W-1:0] out_y_r;
  logic [tgft_pkg::POS_W-1:0] out_z_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      out_leg_r  <= s3_tag_r.leg;
      out_last_r <= s3_tag_r.last;
      out_x_r    <= fx;
      out_y_r    <= fy;
      out_z_r    <= fz;
    end
  end

  assign out_foot.valid    = out_valid_r;
  assign out_foot.leg      = out_leg_r;
  assign out_foot.last_leg = out_last_r;
  assign out_foot.foot_x   = out_x_r;
  assign out_foot.foot_y   = out_y_r;
  assign out_foot.foot_z   = out_z_r;

  `TGFT_ASSERT_NEXT(a_walk_tick_starts_leg0, clk, rst_n, in_fire && walking,
    hold_valid_r && (leg_cnt_r == '0), "walking tick did not start at leg 0")

  `TGFT_ASSERT_NEXT(a_stop_tick_keeps_phase, clk, rst_n, in_fire && !walking,
    $stable(phase_r), "gait phase moved on a stop tick")

  `TGFT_ASSERT_NOW(a_last_flag_on_last_leg, clk, rst_n, out_valid_r,
    out_last_r == (out_leg_r == tgft_pkg::LAST_LEG), "last_leg flag out of step with leg")

endmodule

// ===== sim/tb_trot_gait_foot_trajectory_unit.sv =====
`timescale 1ns / 1ps

module tb_trot_gait_foot_trajectory_unit;

  localparam int TRIG_DEPTH     = 256;
  localparam int PHASE_BITS     = 16;
  localparam logic [15:0] HALF_CYCLE = 16'h8000;
  localparam int POS_MAX        = 65535;
  localparam int POS_MIN        = -65536;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct {
    logic [tgft_pkg::LEG_W-1:0]        leg;
    logic signed [tgft_pkg::POS_W-1:0] x;
    logic signed [tgft_pkg::POS_W-1:0] y;
    logic signed [tgft_pkg::POS_W-1:0] z;
    logic                              last;
  } foot_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [tgft_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [tgft_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  logic tick_vld = 1'b0;
  logic [tgft_pkg::ELAPSED_W-1:0] tick_ms = '0;
  logic tick_taken = 1'b0;
  logic foot_rdy = 1'b0;

  tgft_tick_if tick_if ();
  tgft_foot_if foot_if ();

  assign tick_if.valid      = tick_vld;
  assign tick_if.elapsed_ms = tick_ms;
  assign foot_if.ready      = foot_rdy;

  trot_gait_foot_trajectory_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tick   (tick_if),
    .out_foot  (foot_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // shadow registers and gait state
  logic [tgft_pkg::MODE_W-1:0]       mode_r   = tgft_pkg::MODE_STOP;
  logic signed [tgft_pkg::POS_W-1:0] bx_r     = 17'sd0;
  logic signed [tgft_pkg::POS_W-1:0] by_r     = -17'sd1280;
  logic signed [tgft_pkg::POS_W-1:0] bz_r     = 17'sd448;
  logic [tgft_pkg::LEN_W-1:0]        stride_r = 12'd1280;
  logic [tgft_pkg::LEN_W-1:0]        lift_r   = 12'd240;
  logic [tgft_pkg::RATE_W-1:0]       rate_r   = 16'd98;
  logic [PHASE_BITS-1:0]             phase_r  = '0;

  int sine_q16 [0:TRIG_DEPTH];

  logic [tgft_pkg::ELAPSED_W-1:0] tick_q [$];
  foot_t foot_q [$];

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int err_cnt = 0;
  int idle_cycles = 0;

  function automatic longint horner_term(longint c, longint r, longint unsigned s);
    longint unsigned ru;
    ru = (r < 0) ? 0 : r;
    return c - longint'((ru * s) >> 30);
  endfunction

  task automatic build_sine_table();
    longint unsigned t;
    longint unsigned s;
    longint r;
    for (int k = 0; k <= TRIG_DEPTH; k++) begin
      t = longint'(TRIG_DEPTH - k) << 30;
      t = t / TRIG_DEPTH;
      s = (t * t) >> 30;
      r = 27060;
      r = horner_term(987048, r, s);
      r = horner_term(22401992, r, s);
      r = horner_term(272375560, r, s);
      r = horner_term(1324675879, r, s);
      r = horner_term(1073741824, r, s);
      if (r < 0) r = 0;
      r = (r + 8192) >>> 14;
      if (r > 65536) r = 65536;
      sine_q16[k] = int'(r);
    end
  endtask

  function automatic int sat_pos(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return int'(v);
  endfunction

  function automatic int dir_sign(logic [tgft_pkg::MODE_W-1:0] m, int leg, bit z_axis);
    case (m)
      tgft_pkg::MODE_FORWARD:      return z_axis ? 0 : -1;
      tgft_pkg::MODE_BACKWARD:     return z_axis ? 0 : 1;
      tgft_pkg::MODE_STRAFE_LEFT:  return z_axis ? -1 : 0;
      tgft_pkg::MODE_STRAFE_RIGHT: return z_axis ? 1 : 0;
      tgft_pkg::MODE_ROTATE_LEFT:
        return z_axis ? ((leg < 2) ? -1 : 1) : ((leg % 2 == 0) ? 1 : -1);
      tgft_pkg::MODE_ROTATE_RIGHT:
        return z_axis ? ((leg < 2) ? 1 : -1) : ((leg % 2 == 0) ? -1 : 1);
      default:                     return 0;
    endcase
  endfunction

  // base plus half stride times the signed q16 move, rounded away from zero
  function automatic int move_coord(int base, int dir, int mv);
    bit neg;
    longint mag;
    longint off;
    if (dir == 0) return base;
    neg = (mv < 0) != (dir < 0);
    mag = longint'(stride_r) * ((mv < 0) ? -mv : mv);
    mag = (mag + 65536) >>> 17;
    off = neg ? -mag : mag;
    return sat_pos(longint'(base) + off);
  endfunction

  task automatic predict_feet(logic [tgft_pkg::ELAPSED_W-1:0] ms);
    longint unsigned adv;
    logic [PHASE_BITS-1:0] lp;
    logic [PHASE_BITS-1:0] prog;
    int a;
    int sn;
    int cs;
    int mv;
    longint dy;
    bit swing;
    foot_t f;
    if (mode_r == tgft_pkg::MODE_STOP || mode_r == tgft_pkg::MODE_UNUSED) return;
    adv = ms;
    adv = adv * rate_r;
    phase_r = phase_r + adv[PHASE_BITS-1:0];
    for (int leg = 0; leg < tgft_pkg::NUM_LEGS; leg++) begin
      lp = (leg == 1 || leg == 2) ? phase_r + HALF_CYCLE : phase_r;
      swing = lp < HALF_CYCLE;
      prog = swing ? lp : lp - HALF_CYCLE;
      a = (int'(prog) * 2 * TRIG_DEPTH) >> (PHASE_BITS - 1);
      if (a >= 2 * TRIG_DEPTH) a = 2 * TRIG_DEPTH - 1;
      if (a <= TRIG_DEPTH) begin
        sn = sine_q16[a];
        cs = sine_q16[TRIG_DEPTH - a];
      end else begin
        sn = sine_q16[2 * TRIG_DEPTH - a];
        cs = -sine_q16[a - TRIG_DEPTH];
      end
      if (swing) begin
        dy = (longint'(lift_r) * sn + 32768) >>> 16;
        f.y = tgft_pkg::POS_W'(sat_pos(longint'(by_r) + dy));
        mv = -cs;
      end else begin
        f.y = by_r;
        mv = cs;
      end
      f.x = tgft_pkg::POS_W'(move_coord(bx_r, dir_sign(mode_r, leg, 1'b0), mv));
      f.z = tgft_pkg::POS_W'(move_coord(bz_r, dir_sign(mode_r, leg, 1'b1), mv));
      f.leg = tgft_pkg::LEG_W'(leg);
      f.last = (leg == tgft_pkg::NUM_LEGS - 1);
      foot_q.push_back(f);
    end
  endtask

  task automatic report(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  task automatic cfg_write(tgft_pkg::cfg_idx_t idx, logic [tgft_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tgft_pkg::CFG_GAIT_MODE:     mode_r = data[tgft_pkg::MODE_W-1:0];
      tgft_pkg::CFG_BASE_X:        bx_r = data;
      tgft_pkg::CFG_BASE_Y:        by_r = data;
      tgft_pkg::CFG_BASE_Z:        bz_r = data;
      tgft_pkg::CFG_STRIDE_LENGTH: stride_r = data[tgft_pkg::LEN_W-1:0];
      tgft_pkg::CFG_LIFT_HEIGHT:   lift_r = data[tgft_pkg::LEN_W-1:0];
      tgft_pkg::CFG_PHASE_RATE:    rate_r = data[tgft_pkg::RATE_W-1:0];
      default: ;
    endcase
  endtask

  // stop-mode ticks give no words, so leave the pipe time to empty
  task automatic wait_drained();
    do @(negedge clk); while (tick_q.size() != 0 || foot_q.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [tgft_pkg::CFG_DATA_W-1:0] mode_word(
      logic [tgft_pkg::MODE_W-1:0] m);
    logic [tgft_pkg::CFG_DATA_W-1:0] w;
    w = tgft_pkg::CFG_DATA_W'($urandom());
    w[tgft_pkg::MODE_W-1:0] = m;
    return w;
  endfunction

  function automatic logic [tgft_pkg::CFG_DATA_W-1:0] rand_reg(tgft_pkg::cfg_idx_t idx);
    logic [tgft_pkg::CFG_DATA_W-1:0] w;
    int kind;
    w = tgft_pkg::CFG_DATA_W'($urandom());
    kind = $urandom_range(0, 3);
    if (idx == tgft_pkg::CFG_BASE_X || idx == tgft_pkg::CFG_BASE_Y ||
        idx == tgft_pkg::CFG_BASE_Z) begin
      case (kind)
        0: w = 17'h10000;
        1: w = 17'h0FFFF;
        2: ;
        default: w = tgft_pkg::CFG_DATA_W'(int'($urandom_range(0, 4095)) - 2048);
      endcase
    end else if (idx == tgft_pkg::CFG_PHASE_RATE) begin
      case (kind)
        0: w[tgft_pkg::RATE_W-1:0] = '0;
        1: w[tgft_pkg::RATE_W-1:0] = '1;
        2: ;
        default: w[tgft_pkg::RATE_W-1:0] = tgft_pkg::RATE_W'($urandom_range(1, 1500));
      endcase
    end else begin
      case (kind)
        0: w[tgft_pkg::LEN_W-1:0] = '0;
        1: w[tgft_pkg::LEN_W-1:0] = '1;
        default: ;
      endcase
    end
    return w;
  endfunction

  // tick driver
  always @(posedge clk) begin
    tick_taken <= rst_n && tick_vld && tick_if.ready;
  end

  always @(negedge clk) begin
    if (tick_taken) begin
      predict_feet(tick_ms);
      void'(tick_q.pop_front());
    end
    if (!rst_n) begin
      tick_vld <= 1'b0;
    end else if (!tick_vld || tick_taken) begin
      if (tick_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        tick_vld <= 1'b1;
        tick_ms  <= tick_q[0];
      end else begin
        tick_vld <= 1'b0;
      end
    end
  end

  // foot word receiver
  always @(negedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      foot_rdy <= 1'b0;
    end else begin
      foot_rdy <= rst_n && ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // foot word checker
  always @(posedge clk) begin
    foot_t e;
    if (rst_n && foot_if.valid && foot_rdy) begin
      if (foot_q.size() == 0) begin
        report($sformatf("unexpected foot word: leg %0d x %0d y %0d z %0d last %0d",
                         foot_if.leg, foot_if.foot_x, foot_if.foot_y, foot_if.foot_z,
                         foot_if.last_leg));
      end else begin
        e = foot_q.pop_front();
        if (foot_if.leg !== e.leg || foot_if.foot_x !== e.x || foot_if.foot_y !== e.y ||
            foot_if.foot_z !== e.z || foot_if.last_leg !== e.last) begin
          report($sformatf({"foot word mismatch: expected leg %0d x %0d y %0d z %0d last %0d",
                            "\n  got leg %0d x %0d y %0d z %0d last %0d"},
                           e.leg, e.x, e.y, e.z, e.last, foot_if.leg, foot_if.foot_x,
                           foot_if.foot_y, foot_if.foot_z, foot_if.last_leg));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((tick_vld && tick_if.ready) || (foot_if.valid && foot_rdy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [tgft_pkg::ELAPSED_W-1:0] ms;
    build_sine_table();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // stop mode from reset
    tick_q.push_back(16'd100);
    tick_q.push_back(16'hFFFF);
    wait_drained();

    // reset settings, then half-cycle and wrap boundaries
    cfg_write(tgft_pkg::CFG_GAIT_MODE, mode_word(tgft_pkg::MODE_FORWARD));
    tick_q.push_back(16'd0);
    tick_q.push_back(16'hFFFF);
    wait_drained();
    cfg_write(tgft_pkg::CFG_PHASE_RATE, 17'd1);
    tick_q.push_back(16'd98);
    tick_q.push_back(16'd16384);
    tick_q.push_back(16'd16384);
    tick_q.push_back(16'd32767);
    tick_q.push_back(16'd1);
    wait_drained();
    cfg_write(tgft_pkg::CFG_PHASE_RATE, 17'h1FFFF);
    tick_q.push_back(16'hFFFF);
    wait_drained();

    // saturation at both ends, zero stride and lift, the remaining modes
    cfg_write(tgft_pkg::CFG_GAIT_MODE, mode_word(tgft_pkg::MODE_BACKWARD));
    cfg_write(tgft_pkg::CFG_BASE_X, 17'h0FFFF);
    cfg_write(tgft_pkg::CFG_BASE_Y, 17'h0FFFF);
    cfg_write(tgft_pkg::CFG_STRIDE_LENGTH, 17'h1FFFF);
    cfg_write(tgft_pkg::CFG_LIFT_HEIGHT, 17'h00FFF);
    cfg_write(tgft_pkg::CFG_PHASE_RATE, 17'd700);
    tick_q.push_back(16'd3000);
    tick_q.push_back(16'd5000);
    wait_drained();
    cfg_write(tgft_pkg::CFG_GAIT_MODE, mode_word(tgft_pkg::MODE_STRAFE_LEFT));
    cfg_write(tgft_pkg::CFG_BASE_Y, 17'h10000);
    cfg_write(tgft_pkg::CFG_BASE_Z, 17'h10000);
    tick_q.push_back(16'd40);
    tick_q.push_back(16'd9000);
    wait_drained();
    cfg_write(tgft_pkg::CFG_GAIT_MODE, mode_word(tgft_pkg::MODE_STRAFE_RIGHT));
    cfg_write(tgft_pkg::CFG_STRIDE_LENGTH, 17'h1F000);
    cfg_write(tgft_pkg::CFG_LIFT_HEIGHT, 17'h1F000);
    cfg_write(tgft_pkg::CFG_BASE_Z, 17'h0FFFF);
    tick_q.push_back(16'd11);
    tick_q.push_back(16'd23);
    wait_drained();
    cfg_write(tgft_pkg::CFG_GAIT_MODE, mode_word(tgft_pkg::MODE_ROTATE_LEFT));
    cfg_write(tgft_pkg::CFG_STRIDE_LENGTH, 17'h00FFF);
    cfg_write(tgft_pkg::CFG_BASE_X, 17'h10000);
    tick_q.push_back(16'd77);
    tick_q.push_back(16'd150);
    wait_drained();
    cfg_write(tgft_pkg::CFG_GAIT_MODE, mode_word(tgft_pkg::MODE_ROTATE_RIGHT));
    cfg_write(tgft_pkg::CFG_BASE_X, 17'd0);
    cfg_write(tgft_pkg::CFG_BASE_Z, 17'd0);
    tick_q.push_back(16'd200);
    tick_q.push_back(16'd33);
    wait_drained();
    cfg_write(tgft_pkg::CFG_GAIT_MODE, mode_word(tgft_pkg::MODE_UNUSED));
    tick_q.push_back(16'd5);
    tick_q.push_back(16'hFFFF);

    for (int p = 0; p < 10; p++) begin
      wait_drained();
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 47; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 47; end
        default: begin src_idle_pct = 31; snk_stall_pct = 31; end
      endcase
      if (p % 3 == 2) begin
        cfg_write(tgft_pkg::CFG_GAIT_MODE,
                  mode_word((p % 2 == 1) ? tgft_pkg::MODE_UNUSED : tgft_pkg::MODE_STOP));
        repeat (3) tick_q.push_back(tgft_pkg::ELAPSED_W'($urandom_range(0, 65535)));
        wait_drained();
      end
      for (int i = tgft_pkg::CFG_BASE_X; i <= tgft_pkg::CFG_PHASE_RATE; i++) begin
        cfg_write(tgft_pkg::cfg_idx_t'(i), rand_reg(tgft_pkg::cfg_idx_t'(i)));
      end
      cfg_write(tgft_pkg::CFG_GAIT_MODE,
                mode_word(tgft_pkg::MODE_W'($urandom_range(tgft_pkg::MODE_FORWARD,
                                                            tgft_pkg::MODE_ROTATE_RIGHT))));
      repeat (28) begin
        ms = ($urandom_range(0, 7) == 0) ? tgft_pkg::ELAPSED_W'($urandom_range(0, 65535))
                                         : tgft_pkg::ELAPSED_W'($urandom_range(0, 40));
        tick_q.push_back(ms);
      end
      if (p == 5) begin
        @(posedge clk);
        hold_requests = hold_requests + 1;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tgft_pkg.sv
hw/rtl/tgft_ifs.sv
hw/rtl/tgft_trig_lut.sv
hw/rtl/trot_gait_foot_trajectory_unit.sv
sim/tb_trot_gait_foot_trajectory_unit.sv
